// ===== rtl/core/mrfc_pkg.sv =====
`default_nettype none

package mrfc_pkg;

    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned CRC_SPAN  = 5;
    localparam int unsigned COUNT_CAP = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // positions of the stored bytes within the frame
    localparam logic [3:0] POS_VALUE_HIGH = 4'd3;
    localparam logic [3:0] POS_VALUE_LOW  = 4'd4;
    localparam logic [3:0] POS_CRC_LOW    = 4'd5;
    localparam logic [3:0] POS_CRC_HIGH   = 4'd6;

    localparam int unsigned OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LONG  = 2'd1,
        ST_SHORT = 2'd2,
        ST_CRC   = 2'd3
    } t_status;

    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_CLOSE = 1'b1
    } t_cmd;

    // one byte of reflected crc-16, bit steps unrolled
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/modbus_reply_frame_checker_unit.sv =====
`default_nettype none
// checks a seven-byte modbus register-read reply frame
// slave stream: each beat carries one received byte in tdata[7:0]; tuser[0] set
//   marks the close of the receive window (tdata then ignored)
// master stream: one beat per close, tdata[15:0] register value, tdata[17:16]
//   status (0 ok, 1 too long, 2 too short, 3 crc mismatch), tdata[23:18] zero
// the running crc-16/modbus covers frame bytes zero to four and is compared
//   against bytes five (low) and six (high); value is zero unless status is ok
// a close beat passes through the input register, then the result register,
//   before it shows up on the master side
// throughput: one beat per cycle on the slave side while no close beat waits;
//   the crc byte update is an unrolled xor network between the input and state registers
// a stalled master holds its beat; the input register still drains byte beats
//   and only a close beat waits for the result register to free up
// reset clears the frame state and the valid bits of the input and result registers;
//   after every close the frame state returns to its reset values
module modbus_reply_frame_checker_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_axis_tuser,   // [0] cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [mrfc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata // [15:0] reg_value, [17:16] status
);

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;

    logic [15:0] r_crc,       n_crc;
    logic [3:0]  r_count,     n_count;
    logic [7:0]  r_val_hi,    n_val_hi;
    logic [7:0]  r_val_lo,    n_val_lo;
    logic [7:0]  r_crc_lo,    n_crc_lo;
    logic [7:0]  r_crc_hi,    n_crc_hi;

    logic        r_out_valid;
    logic [15:0] r_out_value, n_out_value;
    logic [1:0]  r_out_status;
    mrfc_pkg::t_status n_status;

    logic out_free;
    logic advance;
    logic in_take;
    logic close_now;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign advance   = r_in_valid && ((r_in_cmd == mrfc_pkg::CMD_BYTE) || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take   = i_s_axis_tvalid && o_s_axis_tready;
    assign close_now = advance && (r_in_cmd == mrfc_pkg::CMD_CLOSE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_comb begin
        logic [15:0] rx_crc;
        n_crc    = r_crc;
        n_count  = r_count;
        n_val_hi = r_val_hi;
        n_val_lo = r_val_lo;
        n_crc_lo = r_crc_lo;
        n_crc_hi = r_crc_hi;
        n_status = mrfc_pkg::ST_OK;
        n_out_value = 16'h0000;
        rx_crc = {r_crc_hi, r_crc_lo};

        priority if (r_count > 4'(mrfc_pkg::FRAME_LEN)) begin
            n_status = mrfc_pkg::ST_LONG;
        end else if (r_count < 4'(mrfc_pkg::FRAME_LEN)) begin
            n_status = mrfc_pkg::ST_SHORT;
        end else if (rx_crc != r_crc) begin
            n_status = mrfc_pkg::ST_CRC;
        end else begin
            n_status = mrfc_pkg::ST_OK;
            n_out_value = {r_val_hi, r_val_lo};
        end

        if (advance) begin
            if (r_in_cmd == mrfc_pkg::CMD_CLOSE) begin
                n_crc    = mrfc_pkg::CRC_INIT;
                n_count  = 4'd0;
                n_val_hi = 8'h00;
                n_val_lo = 8'h00;
                n_crc_lo = 8'h00;
                n_crc_hi = 8'h00;
            end else begin
                if (r_count < 4'(mrfc_pkg::CRC_SPAN)) begin
                    n_crc = mrfc_pkg::crc_update(r_crc, r_in_byte);
                end
                if (r_count == mrfc_pkg::POS_VALUE_HIGH) begin
                    n_val_hi = r_in_byte;
                end
                if (r_count == mrfc_pkg::POS_VALUE_LOW) begin
                    n_val_lo = r_in_byte;
                end
                if (r_count == mrfc_pkg::POS_CRC_LOW) begin
                    n_crc_lo = r_in_byte;
                end
                if (r_count == mrfc_pkg::POS_CRC_HIGH) begin
                    n_crc_hi = r_in_byte;
                end
                // saturate so extra bytes only mark the frame as too long
                if (r_count < 4'(mrfc_pkg::COUNT_CAP)) begin
                    n_count = r_count + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= mrfc_pkg::CRC_INIT;
            r_count  <= 4'd0;
            r_val_hi <= 8'h00;
            r_val_lo <= 8'h00;
            r_crc_lo <= 8'h00;
            r_crc_hi <= 8'h00;
        end else begin
            r_crc    <= n_crc;
            r_count  <= n_count;
            r_val_hi <= n_val_hi;
            r_val_lo <= n_val_lo;
            r_crc_lo <= n_crc_lo;
            r_crc_hi <= n_crc_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (close_now) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (close_now) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b000000, r_out_status, r_out_value};

endmodule

`default_nettype wire

// ===== rtl/core/mrfc_checker.sv =====
`default_nettype none

module mrfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [7:0]  i_s_axis_tdata,
    input wire logic        i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [mrfc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // nothing is offered on the master side right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("master beat valid right after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled master beat changed");

    // a failed frame reports a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[17:16] != mrfc_pkg::ST_OK) |->
            o_m_axis_tdata[15:0] == 16'h0000)
        else $error("nonzero value on failed frame");

    // a result beat only rises after a close beat was taken or while the slave side was stalled
    a_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser, 2) ||
            $past(!o_s_axis_tready, 2))
        else $error("result beat without a close beat");

    // padding bits stay clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[23:18] == 6'b000000)
        else $error("master tdata padding not zero");

endmodule

bind modbus_reply_frame_checker_unit mrfc_checker u_mrfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/modbus_reply_frame_checker_unit_tb.sv =====
module modbus_reply_frame_checker_unit_tb;

    localparam int IDLE_PCT     = 24;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TOTAL_BEATS  = 950;

    typedef struct packed {
        logic [15:0]       value;
        mrfc_pkg::t_status status;
    } reply_t;

    typedef logic [7:0] octet_q_t[$];

    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic [7:0]                       i_s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic                             i_s_axis_tuser  = 1'b0;   // [0] cmd
    logic                             i_m_axis_tready = 1'b0;
    logic                             o_s_axis_tready;
    logic                             o_m_axis_tvalid;
    // [15:0] reg_value, [17:16] status
    logic [mrfc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    // frame state of the predictor
    logic [15:0] crc_run;
    logic [3:0]  rx_count;
    logic [7:0]  value_hi;
    logic [7:0]  value_lo;
    logic [7:0]  crc_lo;
    logic [7:0]  crc_hi;

    reply_t expected_replies[$];
    int     error_count = 0;
    int     beats_sent  = 0;
    int     replies_seen = 0;
    int     status_seen[4] = '{0, 0, 0, 0};
    int     idle_cycles = 0;
    bit     no_idle = 1'b0;

    modbus_reply_frame_checker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bit-serial form of the reflected crc: each data bit enters at the tap
    function automatic logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] data);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ mrfc_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void frame_clear();
        crc_run  = mrfc_pkg::CRC_INIT;
        rx_count = 4'd0;
        value_hi = 8'h00;
        value_lo = 8'h00;
        crc_lo   = 8'h00;
        crc_hi   = 8'h00;
    endfunction

    function automatic void frame_accept(mrfc_pkg::t_cmd cmd, logic [7:0] data);
        reply_t rep;
        if (cmd == mrfc_pkg::CMD_BYTE) begin
            if (rx_count < mrfc_pkg::CRC_SPAN) begin
                crc_run = crc_fold(crc_run, data);
            end
            case (rx_count)
                mrfc_pkg::POS_VALUE_HIGH: value_hi = data;
                mrfc_pkg::POS_VALUE_LOW:  value_lo = data;
                mrfc_pkg::POS_CRC_LOW:    crc_lo   = data;
                mrfc_pkg::POS_CRC_HIGH:   crc_hi   = data;
                default: ;
            endcase
            if (rx_count < mrfc_pkg::COUNT_CAP) begin
                rx_count = rx_count + 4'd1;
            end
        end else begin
            rep.value = 16'h0000;
            if (rx_count > mrfc_pkg::FRAME_LEN) begin
                rep.status = mrfc_pkg::ST_LONG;
            end else if (rx_count < mrfc_pkg::FRAME_LEN) begin
                rep.status = mrfc_pkg::ST_SHORT;
            end else if ({crc_hi, crc_lo} != crc_run) begin
                rep.status = mrfc_pkg::ST_CRC;
            end else begin
                rep.status = mrfc_pkg::ST_OK;
                rep.value  = {value_hi, value_lo};
            end
            expected_replies.push_back(rep);
            frame_clear();
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // append the crc of the first five bytes, low byte first
    function automatic octet_q_t seal_frame(octet_q_t head);
        logic [15:0] crc;
        octet_q_t    frame;
        crc = mrfc_pkg::CRC_INIT;
        foreach (head[i]) begin
            crc = crc_fold(crc, head[i]);
        end
        frame = head;
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        return frame;
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(mrfc_pkg::t_cmd cmd, logic [7:0] data);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= cmd;
        @(negedge i_clk);
        while (!o_s_axis_tready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        frame_accept(cmd, data);
        beats_sent++;
    endtask

    task automatic send_frame(octet_q_t frame, logic [7:0] close_data);
        foreach (frame[i]) begin
            send_beat(mrfc_pkg::CMD_BYTE, frame[i]);
        end
        send_beat(mrfc_pkg::CMD_CLOSE, close_data);
    endtask

    task automatic send_random_frame();
        octet_q_t frame;
        int       kind;
        int       len;
        int       idx;
        kind = $urandom_range(99);
        if (kind < 78) begin
            for (int i = 0; i < mrfc_pkg::CRC_SPAN; i++) begin
                frame.push_back(pick_byte());
            end
            frame = seal_frame(frame);
            // corrupt one bit somewhere in the frame
            if (kind >= 65) begin
                idx = $urandom_range(mrfc_pkg::FRAME_LEN - 1);
                frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(7));
            end
        end else begin
            len = (kind < 90) ? $urandom_range(mrfc_pkg::FRAME_LEN - 1)
                              : $urandom_range(16, mrfc_pkg::FRAME_LEN + 1);
            for (int i = 0; i < len; i++) begin
                frame.push_back(pick_byte());
            end
        end
        send_frame(frame, pick_byte());
    endtask

    task automatic test_directed();
        octet_q_t frame;
        // good reply carrying the largest value
        frame = seal_frame({8'h01, 8'h03, 8'h02, 8'hFF, 8'hFF});
        send_frame(frame, 8'h00);
        // close with nothing received, data bits set but ignored
        send_beat(mrfc_pkg::CMD_CLOSE, 8'hFF);
        // right length, crc high byte broken
        frame = seal_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        frame[mrfc_pkg::POS_CRC_HIGH] = frame[mrfc_pkg::POS_CRC_HIGH] ^ 8'h80;
        send_frame(frame, 8'h5A);
        // valid frame followed by one extra byte
        frame = seal_frame({8'hFE, 8'h04, 8'h02, 8'h00, 8'h00});
        frame.push_back(8'hA5);
        send_frame(frame, 8'h00);
    endtask

    task automatic test_random_frames(int upto);
        while (beats_sent < upto) begin
            send_random_frame();
        end
    endtask

    task automatic test_unbroken_stream();
        no_idle = 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_random_frame();
        end
        no_idle = 1'b0;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // sampled mid-cycle: a beat seen here is taken at the next rising edge
    always @(negedge i_clk) begin
        reply_t      want;
        logic [15:0] got_value;
        logic [1:0]  got_status;
        got_value  = o_m_axis_tdata[15:0];
        got_status = o_m_axis_tdata[17:16];
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply beat, value %h status %0d",
                         $time, got_value, got_status);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (got_value !== want.value) begin
                    $display("%0t: reg_value expected %h actual %h",
                             $time, want.value, got_value);
                    error_count++;
                end
                if (got_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got_status);
                    error_count++;
                end
                if (o_m_axis_tdata[mrfc_pkg::OUT_TDATA_W-1:18] !== '0) begin
                    $display("%0t: pad bits expected 0 actual %h",
                             $time, o_m_axis_tdata[mrfc_pkg::OUT_TDATA_W-1:18]);
                    error_count++;
                end
                replies_seen++;
                status_seen[want.status]++;
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d replies outstanding",
                     $time, idle_cycles, expected_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        frame_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_frames(TOTAL_BEATS / 2);
        test_unbroken_stream();
        test_random_frames(TOTAL_BEATS);
        wait_drained();
        $display("sent %0d beats, checked %0d replies", beats_sent, replies_seen);
        $display("status mix: ok %0d, too long %0d, too short %0d, crc mismatch %0d",
                 status_seen[mrfc_pkg::ST_OK], status_seen[mrfc_pkg::ST_LONG],
                 status_seen[mrfc_pkg::ST_SHORT], status_seen[mrfc_pkg::ST_CRC]);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
